/* rtl/ipru_pkg.sv */
package ipru_pkg;

  // Default depth of the row store in pixels
  localparam int MaxRowPixelsDef = 1024;

  // Pixel and field widths
  localparam int PixW      = 24;
  localparam int ChanW     = 8;
  localparam int ScaleW    = 7;
  localparam int WidthW    = 11;
  localparam int PadW      = 2;
  localparam int CfgAddrW  = 1;
  localparam int CfgDataW  = 11;
  localparam int OutTdataW = 32;

  // Register reset values
  localparam logic [ScaleW-1:0] ScaleRst = ScaleW'(1);
  localparam logic [WidthW-1:0] WidthRst = WidthW'(1);

  // Register indexes
  localparam logic [CfgAddrW-1:0] REG_SCALE = 1'b0;
  localparam logic [CfgAddrW-1:0] REG_WIDTH = 1'b1;

  // Operation codes on the input tuser
  localparam logic FUNC_LOAD    = 1'b0;
  localparam logic FUNC_REQUEST = 1'b1;

  // Side information of one result, travels with the store read
  typedef struct packed {
    logic [PadW-1:0] pad;
    logic            rend;
    logic            done;
  } meta_t;

  // One finished result word
  typedef struct packed {
    logic [PixW-1:0] pix;
    meta_t           meta;
  } result_t;

endpackage

/* rtl/integer_pixel_replication_upscaler.sv */
// Integer pixel replication upscaler for 24-bit RGB rows.
// Input words on s_axis: tuser selects the operation, 0 loads the pixel in
// tdata into the row store, 1 requests the next output pixel. Once row_width
// pixels are loaded the block emits; after scale_factor passes over the row,
// each pixel scale_factor times per pass, it returns to loading. Loads while
// emitting and requests while loading are dropped without a result.
// Output words on m_axis carry the pixel and the pad byte count, tuser flags
// the end of an output row and tlast the end of the last repeated row.
// Configuration goes through cfg_we_i / cfg_addr_i / cfg_wdata_i, index 0 is
// scale_factor and index 1 is row_width; write only while the block is idle.
// Throughput: one word per clock in either mode while s_axis_tready is high.
// A result is registered in the row store read and then in the four-word
// result queue on the output before it reaches m_axis; when the receiver
// stalls the queue fills and s_axis_tready drops, no word is lost.
// Reset clears the counters and returns to loading mode; the registers go to
// one. The row store is not cleared and needs no clearing pass.
module integer_pixel_replication_upscaler
  import ipru_pkg::*;
#(
  parameter int MAX_ROW_PIXELS = MaxRowPixelsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CfgAddrW-1:0]  cfg_addr_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i,
  // input stream
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [PixW-1:0]      s_axis_tdata,  // in_blue, in_green, in_red
  input  logic                 s_axis_tuser,  // func
  // output stream
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [OutTdataW-1:0] m_axis_tdata,  // out_blue, out_green, out_red, pad_bytes
  output logic                 m_axis_tuser,  // row_end
  output logic                 m_axis_tlast   // source_row_done
);

  localparam int AddrW = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1;

  logic             accept;
  logic             ram_we;
  logic [AddrW-1:0] ram_waddr;
  logic             ram_re;
  logic [AddrW-1:0] ram_raddr;
  logic [PixW-1:0]  ram_rdata;
  meta_t            meta;
  logic             room;
  result_t          result;

  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Counters and store access
  ipru_ctrl #(
    .MAX_ROW_PIXELS (MAX_ROW_PIXELS),
    .AddrW          (AddrW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .func_i      (s_axis_tuser),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .meta_o      (meta)
  );

  // Row store
  ipru_ram #(
    .Width (PixW),
    .Depth (MAX_ROW_PIXELS),
    .AddrW (AddrW)
  ) u_row_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (s_axis_tdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Result queue
  ipru_obuf u_obuf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .issue_i  (ram_re),
    .meta_i   (meta),
    .rdata_i  (ram_rdata),
    .room_o   (room),
    .valid_o  (m_axis_tvalid),
    .ready_i  (m_axis_tready),
    .result_o (result)
  );

  // Pack the output word
  assign m_axis_tdata = {{(OutTdataW - PixW - PadW){1'b0}}, result.meta.pad, result.pix};
  assign m_axis_tuser = result.meta.rend;
  assign m_axis_tlast = result.meta.done;

endmodule

/* rtl/ipru_ram.sv */
module ipru_ram #(
  parameter int Width = 24,
  parameter int Depth = 1024,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/ipru_ctrl.sv */
module ipru_ctrl
  import ipru_pkg::*;
#(
  parameter int MAX_ROW_PIXELS = MaxRowPixelsDef,
  parameter int AddrW = (MAX_ROW_PIXELS > 1) ? $clog2(MAX_ROW_PIXELS) : 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration
  input  logic                cfg_we_i,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  // accepted input word
  input  logic                accept_i,
  input  logic                func_i,
  // row store access
  output logic                ram_we_o,
  output logic [AddrW-1:0]    ram_waddr_o,
  output logic                ram_re_o,
  output logic [AddrW-1:0]    ram_raddr_o,
  // result side information, valid when ram_re_o is high
  output meta_t               meta_o
);

  logic [ScaleW-1:0] scale_q;
  logic [WidthW-1:0] width_q;
  logic [AddrW-1:0]  load_pos_q, load_pos_d;
  logic [AddrW-1:0]  col_q, col_d;
  logic [ScaleW-1:0] hrep_q, hrep_d;
  logic [ScaleW-1:0] vrep_q, vrep_d;
  logic              emit_q, emit_d;

  logic [ScaleW-1:0] eff_scale;
  logic [31:0]       width32;
  logic [31:0]       eff_w32;
  logic              load_last;
  logic              h_last;
  logic              col_last;
  logic              v_last;
  logic              do_load;
  logic              do_req;
  logic [3:0]        pad_prod;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleRst;
      width_q <= WidthRst;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_SCALE: scale_q <= cfg_wdata_i[ScaleW-1:0];
        REG_WIDTH: width_q <= cfg_wdata_i[WidthW-1:0];
        default:   ;
      endcase
    end
  end

  // Effective scale and width: zero acts as one, width clamps to the store
  always_comb begin
    eff_scale = (scale_q == '0) ? ScaleW'(1) : scale_q;
    width32   = 32'(width_q);
    if (width_q == '0) begin
      eff_w32 = 32'd1;
    end else if (width32 > 32'(MAX_ROW_PIXELS)) begin
      eff_w32 = 32'(MAX_ROW_PIXELS);
    end else begin
      eff_w32 = width32;
    end
  end

  // Last-step checks, a counter at or past its limit is on its last step
  assign load_last = (32'(load_pos_q) + 32'd1) >= eff_w32;
  assign col_last  = (32'(col_q) + 32'd1) >= eff_w32;
  assign h_last    = ({1'b0, hrep_q} + 8'd1) >= {1'b0, eff_scale};
  assign v_last    = ({1'b0, vrep_q} + 8'd1) >= {1'b0, eff_scale};

  assign do_load = accept_i && (func_i == FUNC_LOAD) && !emit_q;
  assign do_req  = accept_i && (func_i == FUNC_REQUEST) && emit_q;

  // Row padding: (4 - 3*w*s mod 4) mod 4 reduces to w*s mod 4
  assign pad_prod = eff_w32[1:0] * eff_scale[1:0];

  // Advance counters
  always_comb begin
    load_pos_d  = load_pos_q;
    col_d       = col_q;
    hrep_d      = hrep_q;
    vrep_d      = vrep_q;
    emit_d      = emit_q;
    meta_o.pad  = '0;
    meta_o.rend = 1'b0;
    meta_o.done = 1'b0;
    if (do_load) begin
      if (load_last) begin
        load_pos_d = '0;
        emit_d     = 1'b1;
        col_d      = '0;
        hrep_d     = '0;
        vrep_d     = '0;
      end else begin
        load_pos_d = load_pos_q + AddrW'(1);
      end
    end
    if (do_req) begin
      if (h_last) begin
        hrep_d = '0;
        if (col_last) begin
          col_d       = '0;
          meta_o.rend = 1'b1;
          meta_o.pad  = pad_prod[PadW-1:0];
          if (v_last) begin
            vrep_d      = '0;
            meta_o.done = 1'b1;
            emit_d      = 1'b0;
            load_pos_d  = '0;
          end else begin
            vrep_d = vrep_q + ScaleW'(1);
          end
        end else begin
          col_d = col_q + AddrW'(1);
        end
      end else begin
        hrep_d = hrep_q + ScaleW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_pos_q <= '0;
      col_q      <= '0;
      hrep_q     <= '0;
      vrep_q     <= '0;
      emit_q     <= 1'b0;
    end else begin
      load_pos_q <= load_pos_d;
      col_q      <= col_d;
      hrep_q     <= hrep_d;
      vrep_q     <= vrep_d;
      emit_q     <= emit_d;
    end
  end

  // Store a loaded pixel, fetch a requested one
  assign ram_we_o    = do_load;
  assign ram_waddr_o = load_pos_q;
  assign ram_re_o    = do_req;
  assign ram_raddr_o = col_q;

endmodule

/* rtl/ipru_obuf.sv */
module ipru_obuf
  import ipru_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  // request issued this cycle and its side information
  input  logic            issue_i,
  input  meta_t           meta_i,
  // store read data, valid in the cycle after issue
  input  logic [PixW-1:0] rdata_i,
  // room for one more word in flight
  output logic            room_o,
  // result side
  output logic            valid_o,
  input  logic            ready_i,
  output result_t         result_o
);

  localparam int Depth = 4;
  localparam int PtrW  = 2;
  localparam int CntW  = 3;

  logic            rd_valid_q;
  meta_t           rd_meta_q;
  result_t         fifo_q [Depth];
  logic [PtrW-1:0] wr_ptr_q;
  logic [PtrW-1:0] rd_ptr_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push;
  logic            pop;

  // Hold side information while the store read completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= issue_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue_i) begin
      rd_meta_q <= meta_i;
    end
  end

  assign push = rd_valid_q;
  assign pop  = valid_o && ready_i;

  // Result queue payload
  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= '{pix: rdata_i, meta: rd_meta_q};
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + PtrW'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  // Take a new word only while every word in flight has a queue slot
  assign room_o   = (cnt_q + CntW'(rd_valid_q)) < CntW'(Depth);
  assign valid_o  = (cnt_q != '0);
  assign result_o = fifo_q[rd_ptr_q];

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import ipru_pkg::*;

  localparam int RowDepth    = MaxRowPixelsDef;
  localparam int QuietLimit  = 2000;
  localparam int RandomWords = 90;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CfgAddrW-1:0]  cfg_addr_i = '0;
  logic [CfgDataW-1:0]  cfg_wdata_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [PixW-1:0]      s_axis_tdata = '0;  // in_blue, in_green, in_red
  logic                 s_axis_tuser = 1'b0;  // func
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutTdataW-1:0] m_axis_tdata;  // out_blue, out_green, out_red, pad_bytes
  logic                 m_axis_tuser;  // row_end
  logic                 m_axis_tlast;  // source_row_done

  integer_pixel_replication_upscaler i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_addr_i,
    .cfg_wdata_i,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast
  );

  always #4 clk_i = ~clk_i;

  // Upscaler state as the testbench sees it
  logic [PixW-1:0] row_copy [RowDepth];
  int              fill_pos = 0;
  bit              emit_mode = 1'b0;
  int              col_pos = 0;
  int              h_count = 0;
  int              v_count = 0;
  int              scale_reg = 1;
  int              width_reg = 1;

  result_t pending_pixels[$];
  int      mismatches = 0;
  int      words_taken = 0;
  int      quiet_cycles = 0;

  // Traffic shaping
  bit src_gaps_on = 1'b0;
  bit sink_stalls_on = 1'b0;
  int burst_left = 0;
  bit sink_busy = 1'b0;
  int sink_left = 0;

  function automatic int eff_scale();
    return (scale_reg == 0) ? 1 : scale_reg;
  endfunction

  function automatic int eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > RowDepth) return RowDepth;
    return width_reg;
  endfunction

  // Advance the predicted state by one word; return 1 when a pixel comes out
  function automatic bit upscale_step(input logic func, input logic [PixW-1:0] pix_in,
                                      output result_t res);
    int s;
    int w;
    s = eff_scale();
    w = eff_width();
    res = '0;
    if (func == FUNC_LOAD) begin
      if (emit_mode) return 1'b0;
      words_taken++;
      row_copy[fill_pos] = pix_in;
      if (fill_pos + 1 >= w) begin
        fill_pos  = 0;
        emit_mode = 1'b1;
        col_pos   = 0;
        h_count   = 0;
        v_count   = 0;
      end else begin
        fill_pos++;
      end
      return 1'b0;
    end
    if (!emit_mode) return 1'b0;
    words_taken++;
    res.pix = row_copy[col_pos];
    if (h_count + 1 >= s) begin
      h_count = 0;
      if (col_pos + 1 >= w) begin
        col_pos = 0;
        res.meta.rend = 1'b1;
        res.meta.pad  = PadW'((4 - ((3 * w * s) & 3)) & 3);
        if (v_count + 1 >= s) begin
          v_count = 0;
          res.meta.done = 1'b1;
          emit_mode = 1'b0;
          fill_pos  = 0;
        end else begin
          v_count++;
        end
      end else begin
        col_pos++;
      end
    end else begin
      h_count++;
    end
    return 1'b1;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare each output word with the oldest expected pixel
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_pixels.size() == 0) begin
        $error("output word with no pixel expected: tdata %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("out_blue", want.pix[ChanW-1:0], m_axis_tdata[ChanW-1:0]);
        check_field("out_green", want.pix[2*ChanW-1:ChanW], m_axis_tdata[2*ChanW-1:ChanW]);
        check_field("out_red", want.pix[3*ChanW-1:2*ChanW],
                    m_axis_tdata[3*ChanW-1:2*ChanW]);
        check_field("pad_bytes", want.meta.pad, m_axis_tdata[PixW+PadW-1:PixW]);
        check_field("row_end", want.meta.rend, m_axis_tuser);
        check_field("source_row_done", want.meta.done, m_axis_tlast);
      end
    end
  end

  // Receiver: alternate ready and stall runs of random length
  always @(negedge clk_i) begin
    if (!sink_stalls_on) begin
      m_axis_tready <= 1'b1;
    end else begin
      if (sink_left == 0) begin
        sink_busy = !sink_busy;
        sink_left = sink_busy ? $urandom_range(1, 5) : $urandom_range(1, 10);
      end
      sink_left--;
      m_axis_tready <= !sink_busy;
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("testbench: done, errors");
        $finish;
      end
    end
  end

  // Send one word, with bursts and gaps, and predict its result on acceptance
  task automatic send_word(input logic func, input logic [PixW-1:0] pix);
    result_t res;
    int      gap;
    if (burst_left == 0) begin
      gap = src_gaps_on ? $urandom_range(1, 8) : 0;
      repeat (gap) begin
        @(negedge clk_i);
        s_axis_tvalid <= 1'b0;
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= pix;
    s_axis_tuser  <= func;
    do @(posedge clk_i); while (!s_axis_tready);
    if (upscale_step(func, pix, res)) pending_pixels.push_back(res);
  endtask

  // Drop valid, drain all expected pixels, then let the pipeline empty
  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgAddrW-1:0] idx, input int value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= CfgDataW'(value);
    @(posedge clk_i);
    if (idx == REG_SCALE) scale_reg = value & 'h7f;
    else width_reg = value & 'h7ff;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_row();
    while (!emit_mode) send_word(FUNC_LOAD, PixW'($urandom()));
  endtask

  task automatic finish_row();
    while (emit_mode) send_word(FUNC_REQUEST, PixW'($urandom()));
  endtask

  // Reset values: one pixel wide, no scaling; dropped words in both modes
  task automatic test_reset_values();
    send_word(FUNC_REQUEST, 24'h5a5a5a);
    send_word(FUNC_LOAD, 24'hffffff);
    send_word(FUNC_LOAD, 24'h000000);
    send_word(FUNC_REQUEST, 24'h000000);
    send_word(FUNC_LOAD, 24'h000000);
    send_word(FUNC_REQUEST, 24'hffffff);
    send_word(FUNC_LOAD, 24'ha5c33c);
    send_word(FUNC_REQUEST, 24'h000000);
    wait_idle();
  endtask

  // Oversized width clamps to the full store; fills every entry once,
  // then cut the row short by narrowing it
  task automatic test_full_row();
    write_reg(REG_WIDTH, 2047);
    write_reg(REG_SCALE, 1);
    load_row();
    repeat (3) send_word(FUNC_REQUEST, 24'h0);
    wait_idle();
    write_reg(REG_WIDTH, 1);
    finish_row();
    wait_idle();
  endtask

  // Zero scale and zero width both act as one
  task automatic test_zero_registers();
    write_reg(REG_SCALE, 0);
    write_reg(REG_WIDTH, 0);
    send_word(FUNC_LOAD, 24'h123456);
    send_word(FUNC_REQUEST, 24'h000000);
    wait_idle();
    write_reg(REG_WIDTH, 3);
    load_row();
    finish_row();
    wait_idle();
  endtask

  // Register changes in the middle of loading and of emitting
  task automatic test_mid_row_change();
    write_reg(REG_SCALE, 5);
    write_reg(REG_WIDTH, 6);
    load_row();
    repeat (13) send_word(FUNC_REQUEST, 24'h0);
    wait_idle();
    // horizontal count now past the new limit
    write_reg(REG_SCALE, 2);
    repeat (5) send_word(FUNC_REQUEST, 24'h0);
    wait_idle();
    // column now past the new width
    write_reg(REG_WIDTH, 2);
    finish_row();
    wait_idle();
    write_reg(REG_WIDTH, 4);
    write_reg(REG_SCALE, 3);
    send_word(FUNC_LOAD, PixW'($urandom()));
    send_word(FUNC_LOAD, PixW'($urandom()));
    wait_idle();
    write_reg(REG_WIDTH, 2);
    load_row();
    finish_row();
    wait_idle();
    // widen while emitting
    write_reg(REG_WIDTH, 3);
    write_reg(REG_SCALE, 2);
    load_row();
    repeat (2) send_word(FUNC_REQUEST, 24'h0);
    wait_idle();
    write_reg(REG_WIDTH, 9);
    finish_row();
    wait_idle();
  endtask

  // Largest scale the register holds, one pixel wide; past the first output
  // row, drop the scale so the vertical count ends the row early
  task automatic test_largest_scale();
    write_reg(REG_SCALE, 127);
    write_reg(REG_WIDTH, 1);
    load_row();
    repeat (128) send_word(FUNC_REQUEST, 24'h0);
    wait_idle();
    write_reg(REG_SCALE, 1);
    finish_row();
    wait_idle();
  endtask

  // Random rows with random content, noise words and occasional reconfiguration
  task automatic test_random_rows();
    int stop_at;
    int pick;
    int s;
    int w;
    stop_at = words_taken + RandomWords;
    while (words_taken < stop_at) begin
      if ($urandom_range(0, 3) == 0) begin
        wait_idle();
        pick = $urandom_range(0, 19);
        case (pick)
          0: begin
            s = 0;
            w = $urandom_range(0, 3);
          end
          1: begin
            s = $urandom_range(9, 12);
            w = $urandom_range(0, 1);
          end
          2: begin
            s = $urandom_range(0, 1);
            w = $urandom_range(17, 40);
          end
          3: begin
            s = $urandom_range(5, 8);
            w = $urandom_range(1, 2);
          end
          default: begin
            s = $urandom_range(1, 3);
            w = $urandom_range(1, 8);
          end
        endcase
        write_reg(REG_SCALE, s);
        write_reg(REG_WIDTH, w);
      end
      src_gaps_on    = ($urandom_range(0, 3) != 0);
      sink_stalls_on = ($urandom_range(0, 3) != 0);
      while (!emit_mode) begin
        if ($urandom_range(0, 15) == 0) send_word(FUNC_REQUEST, PixW'($urandom()));
        send_word(FUNC_LOAD, PixW'($urandom()));
      end
      while (emit_mode) begin
        pick = $urandom_range(0, 63);
        if (pick == 0) begin
          send_word(FUNC_LOAD, PixW'($urandom()));
        end else if (pick == 1) begin
          wait_idle();
          if ($urandom_range(0, 1) == 0) write_reg(REG_SCALE, $urandom_range(0, 3));
          else write_reg(REG_WIDTH, $urandom_range(0, 8));
        end
        send_word(FUNC_REQUEST, PixW'($urandom()));
      end
    end
    wait_idle();
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_values();
    test_full_row();
    test_zero_registers();
    sink_stalls_on = 1'b1;
    test_mid_row_change();
    test_largest_scale();
    test_random_rows();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/ipru_pkg.sv
rtl/ipru_ram.sv
rtl/ipru_ctrl.sv
rtl/ipru_obuf.sv
rtl/integer_pixel_replication_upscaler.sv
tb/testbench.sv
